// ===== design/exponential_random_variate_generator_core_macros.svh =====
// assertion macros shared by the exponential variate generator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef EXPONENTIAL_RANDOM_VARIATE_GENERATOR_CORE_MACROS_SVH
`define EXPONENTIAL_RANDOM_VARIATE_GENERATOR_CORE_MACROS_SVH

// condition must hold at every edge out of reset
`define ERV_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ERV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ERV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/erv_pkg.sv =====
// shared types and constants of the exponential variate generator
// no dependencies; imported by the interfaces and all modules
package erv_pkg;

	localparam int unsigned SEED_W     = 31;
	localparam int unsigned DECAY_W    = 32;
	localparam int unsigned VARIATE_W  = 37;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned MANT_FRAC  = 30;

	localparam logic [14:0]       LCG_MULT = 15'd16807;
	localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
	localparam logic [31:0]       LN2_Q32  = 32'd2977044472;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECAY      = 2'd0,
		CFG_START_SEED = 2'd1
	} erv_cfg_idx_t;

	// one result item
	typedef struct packed {
		logic [VARIATE_W-1:0] variate;
		logic [SEED_W-1:0]    new_seed;
	} erv_res_t;

	// operands of the shared multiplier
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} erv_mul_op_t;

	// seed reload from a start seed write
	typedef struct packed {
		logic              load;
		logic [SEED_W-1:0] value;
	} erv_seed_load_t;

	// top level to sequencer control
	typedef struct packed {
		logic start;
		logic res_free;
	} erv_seq_ctl_t;

	// sequencer to top level status
	typedef struct packed {
		logic idle;
		logic done;
	} erv_seq_sts_t;

endpackage

// ===== design/erv_if.sv =====
// valid/ready channel interfaces: request in, result out, configuration write
// depends on erv_pkg
interface erv_req_if;
	import erv_pkg::*;
	logic valid;
	logic ready;
	logic request;
	modport source (output valid, output request, input ready);
	modport sink (input valid, input request, output ready);
endinterface

interface erv_res_if;
	import erv_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [VARIATE_W-1:0] variate;
	logic [SEED_W-1:0]    new_seed;
	modport source (output valid, output variate, output new_seed, input ready);
	modport sink (input valid, input variate, input new_seed, output ready);
endinterface

interface erv_cfg_if;
	import erv_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/erv_mul.sv =====
// shared 32x32 unsigned multiplier used by the seed update, squaring, ln2 and lambda steps
// depends on erv_pkg
module erv_mul (
	input  erv_pkg::erv_mul_op_t op,
	output logic [63:0]          prod
);
	import erv_pkg::*;

	// full product, registered by the consumer
	assign prod = 64'(op.a) * 64'(op.b);

endmodule

// ===== design/erv_seq.sv =====
// sequencer: seed update, iterative binary log and scaling on the shared multiplier
// depends on erv_pkg, erv_mul and the assertion macros header
`include "exponential_random_variate_generator_core_macros.svh"

module erv_seq #(
	parameter int unsigned LOG_FRACTION_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  erv_pkg::erv_seq_ctl_t          ctl,
	input  erv_pkg::erv_seed_load_t        seed_load,
	input  logic [erv_pkg::DECAY_W-1:0]    decay,
	output erv_pkg::erv_seq_sts_t          sts,
	output erv_pkg::erv_res_t              res
);
	import erv_pkg::*;

	localparam int unsigned F  = LOG_FRACTION_BITS;
	localparam int unsigned DW = F + 5;
	localparam int unsigned CW = $clog2(F);

	// binary log of the modulus, worked out at elaboration
	function automatic logic [63:0] log2_mod_const(input int unsigned fb);
		logic [63:0] y;
		logic [63:0] fr;
		y  = 64'(LCG_MOD);
		fr = '0;
		for (int unsigned i = 0; i < fb; i++) begin
			y  = (y * y) >> MANT_FRAC;
			fr = fr << 1;
			if (y >= (64'd2 << MANT_FRAC)) begin
				y  = y >> 1;
				fr = fr | 64'd1;
			end
		end
		return (64'd30 << fb) | fr;
	endfunction

	localparam logic [DW-1:0] LOG2_MOD = DW'(log2_mod_const(F));

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_SEED = 12'b0000_0000_0010,
		S_MOD  = 12'b0000_0000_0100,
		S_SUB  = 12'b0000_0000_1000,
		S_NORM = 12'b0000_0001_0000,
		S_SQR  = 12'b0000_0010_0000,
		S_DIFF = 12'b0000_0100_0000,
		S_LNLO = 12'b0000_1000_0000,
		S_LNHI = 12'b0001_0000_0000,
		S_XLO  = 12'b0010_0000_0000,
		S_XHI  = 12'b0100_0000_0000,
		S_FIN  = 12'b1000_0000_0000
	} state_t;

	state_t               state_q;
	logic [SEED_W-1:0]    seed_q;
	logic [SEED_W-1:0]    y_q;
	logic [4:0]           e_q;
	logic [F-1:0]         frac_q;
	logic [CW-1:0]        cnt_q;
	logic [63:0]          acc_q;
	logic [DW-1:0]        d_q;
	logic [DW-1:0]        n_q;
	logic [VARIATE_W-1:0] variate_q;

	erv_mul_op_t mul_op;
	logic [63:0] prod;
	logic [31:0] mod_sum;
	logic [31:0] mod_red;
	logic [31:0] sq;
	logic [DW-1:0] lv;
	logic [63:0] d_ext;
	logic [63:0] n_ext;
	logic [63:0] x_sum;
	logic        sqr_last;

	erv_mul u_mul (
		.op   (mul_op),
		.prod (prod)
	);

	assign d_ext    = 64'(d_q);
	assign n_ext    = 64'(n_q);
	assign sq       = prod[61:30];
	assign lv       = {e_q, frac_q};
	assign sqr_last = (cnt_q == CW'(F - 1));

	// fold the 46-bit product modulo 2^31-1
	assign mod_sum = 32'(acc_q[45:31]) + 32'(acc_q[30:0]);
	assign mod_red = (mod_sum >= 32'(LCG_MOD)) ? (mod_sum - 32'(LCG_MOD)) : mod_sum;

	// high partial product joined to the shifted low one
	assign x_sum = (prod << (32 - F)) + acc_q;

	// multiplier operand select
	always_comb begin
		mul_op = '0;
		unique case (state_q)
			S_SEED: begin
				mul_op.a = 32'(LCG_MULT);
				mul_op.b = 32'(seed_q);
			end
			S_SQR: begin
				mul_op.a = 32'(y_q);
				mul_op.b = 32'(y_q);
			end
			S_LNLO: begin
				mul_op.a = LN2_Q32;
				mul_op.b = d_ext[31:0];
			end
			S_LNHI: begin
				mul_op.a = LN2_Q32;
				mul_op.b = d_ext[63:32];
			end
			S_XLO: begin
				mul_op.a = decay;
				mul_op.b = n_ext[31:0];
			end
			S_XHI: begin
				mul_op.a = decay;
				mul_op.b = n_ext[63:32];
			end
			default: mul_op = '0;
		endcase
	end

	// control state and generator seed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seed_q  <= SEED_W'(1);
		end else begin
			if (seed_load.load) begin
				seed_q <= seed_load.value;
			end
			unique case (state_q)
				S_IDLE: if (ctl.start) begin
					state_q <= S_SEED;
				end
				S_SEED: state_q <= S_MOD;
				S_MOD: begin
					seed_q  <= mod_red[SEED_W-1:0];
					state_q <= S_SUB;
				end
				S_SUB: state_q <= S_NORM;
				S_NORM: if (y_q[30]) begin
					state_q <= S_SQR;
				end
				S_SQR: if (sqr_last) begin
					state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_LNLO;
				S_LNLO: state_q <= S_LNHI;
				S_LNHI: state_q <= S_XLO;
				S_XLO:  state_q <= S_XHI;
				S_XHI:  state_q <= S_FIN;
				S_FIN: if (ctl.res_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_SEED: acc_q <= prod;
			S_SUB: begin
				y_q   <= LCG_MOD - seed_q;
				e_q   <= 5'd30;
				cnt_q <= '0;
			end
			S_NORM: begin
				// shift up four bits while the top nibble is empty, else one
				priority if (y_q[30]) begin
					y_q <= y_q;
				end else if (y_q[30:27] == 4'd0) begin
					y_q <= {y_q[26:0], 4'd0};
					e_q <= e_q - 5'd4;
				end else begin
					y_q <= {y_q[29:0], 1'b0};
					e_q <= e_q - 5'd1;
				end
			end
			S_SQR: begin
				// one fraction bit per squaring
				if (sq[31]) begin
					y_q    <= sq[31:1];
					frac_q <= {frac_q[F-2:0], 1'b1};
				end else begin
					y_q    <= sq[30:0];
					frac_q <= {frac_q[F-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CW'(1);
			end
			S_DIFF: d_q <= (LOG2_MOD > lv) ? (LOG2_MOD - lv) : '0;
			S_LNLO: acc_q <= prod >> 32;
			S_LNHI: n_q <= DW'(prod + acc_q);
			S_XLO:  acc_q <= prod >> F;
			S_XHI:  variate_q <= x_sum[VARIATE_W-1:0];
			default: acc_q <= acc_q;
		endcase
	end

	assign sts.idle     = (state_q == S_IDLE);
	assign sts.done     = (state_q == S_FIN) && ctl.res_free;
	assign res.variate  = variate_q;
	assign res.new_seed = seed_q;

	`ERV_ASSERT_ALWAYS(a_seed_in_range, clk, arst_n, (seed_q != '0) && (seed_q != LCG_MOD), "seed left 1..m-1")
	`ERV_ASSERT_SAME(a_mant_normal, clk, arst_n, state_q == S_SQR, y_q[30], "log mantissa not normalized")
	`ERV_ASSERT_NEXT(a_result_held, clk, arst_n, (state_q == S_FIN) && !ctl.res_free, $stable(variate_q) && $stable(seed_q), "pending result changed")

endmodule

// ===== design/exponential_random_variate_generator_core.sv =====
// top level of the exponential variate generator: config registers, output register
// depends on erv_pkg, erv_if, erv_seq
//
// Each request with request=1 advances a Park-Miller generator (seed = 16807*seed
// mod 2^31-1) and returns variate = lambda*(log2(m) - log2(m-seed))*ln2 in unsigned
// Q21.16 together with the new seed; a request with request=0 is taken and dropped.
// The logarithm squares its mantissa once per fraction bit, F=24 by default, on the
// single shared 32x32 multiplier, and the length of the mantissa normalization
// depends on the leading zeros of m-seed. req.ready is high
// only between requests; a finished result sits in an output register so the next
// request is accepted while it waits. Configuration writes are always accepted and
// belong only to idle periods; writing start_seed reloads the generator at once.
module exponential_random_variate_generator_core #(
	parameter int unsigned LOG_FRACTION_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	erv_req_if.sink   req,
	erv_res_if.source res,
	erv_cfg_if.sink   cfg
);
	import erv_pkg::*;

	logic [DECAY_W-1:0] decay_q;
	logic               out_valid_q;
	erv_res_t           out_q;

	erv_seq_ctl_t   ctl;
	erv_seq_sts_t   sts;
	erv_seed_load_t seed_load;
	erv_res_t       seq_res;
	logic [SEED_W-1:0] seed_wr;
	logic           cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// low 31 bits of the start seed are reduced mod m, zero stored as one
	assign seed_wr = cfg.data[SEED_W-1:0];
	assign seed_load.load  = cfg_wr && (cfg.index == CFG_START_SEED);
	assign seed_load.value = ((seed_wr == '0) || (seed_wr == LCG_MOD)) ? SEED_W'(1) : seed_wr;

	// lambda register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= 32'd65536;
		end else if (cfg_wr && (cfg.index == CFG_DECAY)) begin
			decay_q <= cfg.data;
		end
	end

	// request handshake
	assign req.ready    = sts.idle;
	assign ctl.start    = req.valid && req.ready && req.request;
	assign ctl.res_free = !out_valid_q || res.ready;

	erv_seq #(
		.LOG_FRACTION_BITS (LOG_FRACTION_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.seed_load (seed_load),
		.decay     (decay_q),
		.sts       (sts),
		.res       (seq_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.done) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done) begin
			out_q <= seq_res;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.variate  = out_q.variate;
	assign res.new_seed = out_q.new_seed;

endmodule

// ===== tb/erv_draw_checker.sv =====
// watches the request, result and config channels of the exponential variate generator,
// predicts every draw and compares it against the result stream
// depends on erv_pkg and erv_if
module erv_draw_checker #(
	parameter int unsigned LOG_FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	erv_req_if          req,
	erv_res_if          res,
	erv_cfg_if          cfg,
	output int unsigned draws_in_flight,
	output int unsigned mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import erv_pkg::*;

	logic [DECAY_W-1:0] decay_q16;
	logic [SEED_W-1:0]  gen_seed;
	erv_res_t           pending_draws[$];
	int unsigned        errors_seen;

	// a start seed of zero or of the modulus itself folds to one
	function automatic logic [SEED_W-1:0] fold_start_seed(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] r;
		r = (s == LCG_MOD) ? '0 : s;
		if (r == '0)
			r = 1;
		return r;
	endfunction

	// park-miller step
	function automatic logic [SEED_W-1:0] advance_seed(input logic [SEED_W-1:0] s);
		logic [63:0] p;
		p = (64'(s) * 64'(LCG_MULT)) % 64'(LCG_MOD);
		if (p == 0)
			p = 1;
		return p[SEED_W-1:0];
	endfunction

	// binary log by repeated squaring of the normalized mantissa, Q.F result
	function automatic logic [63:0] log2_q(input logic [SEED_W-1:0] v);
		int unsigned msb;
		int unsigned k;
		logic [63:0] mant;
		logic [63:0] frac;
		msb = 0;
		frac = '0;
		if (v == '0)
			v = 1;
		for (k = 0; k < SEED_W; k++)
			if (v[k])
				msb = k;
		mant = 64'(v) << (MANT_FRAC - msb);
		repeat (LOG_FRACTION_BITS) begin
			mant = (mant * mant) >> MANT_FRAC;
			frac = frac << 1;
			if (mant >= (64'd2 << MANT_FRAC)) begin
				mant = mant >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(msb) << LOG_FRACTION_BITS) | frac;
	endfunction

	// variate = lambda * ln2 * (log2(m) - log2(m - seed)), truncated at each product
	function automatic erv_res_t draw_variate(input logic [SEED_W-1:0] seed,
			input logic [DECAY_W-1:0] lambda);
		logic [63:0]  lm;
		logic [63:0]  lv;
		logic [63:0]  diff;
		logic [127:0] nat;
		logic [127:0] x;
		erv_res_t     r;
		lm = log2_q(LCG_MOD);
		lv = log2_q(LCG_MOD - seed);
		diff = (lm > lv) ? (lm - lv) : 64'd0;
		nat = (128'(LN2_Q32) * 128'(diff)) >> 32;
		x = (128'(lambda) * 128'(nat[63:0])) >> LOG_FRACTION_BITS;
		r.variate = x[VARIATE_W-1:0];
		r.new_seed = seed;
		return r;
	endfunction

	// track config, queue predictions, compare results in order
	always @(posedge clk or negedge arst_n) begin
		erv_res_t want;
		if (!arst_n) begin
			decay_q16 = 32'd65536;
			gen_seed = 1;
			pending_draws.delete();
			errors_seen = 0;
			draws_in_flight <= 0;
			mismatch_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (erv_cfg_idx_t'(cfg.index))
					CFG_DECAY: begin
						decay_q16 = cfg.data[DECAY_W-1:0];
					end
					CFG_START_SEED: begin
						gen_seed = fold_start_seed(cfg.data[SEED_W-1:0]);
					end
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready && req.request) begin
				gen_seed = advance_seed(gen_seed);
				pending_draws.push_back(draw_variate(gen_seed, decay_q16));
			end
			if (res.valid && res.ready) begin
				if (pending_draws.size() == 0) begin
					$error("unexpected result: variate %0d new_seed %0d",
						res.variate, res.new_seed);
					errors_seen++;
				end else begin
					want = pending_draws.pop_front();
					if (res.variate !== want.variate) begin
						$error("variate: expected %0d, got %0d", want.variate, res.variate);
						errors_seen++;
					end
					if (res.new_seed !== want.new_seed) begin
						$error("new_seed: expected %0d, got %0d", want.new_seed, res.new_seed);
						errors_seen++;
					end
				end
			end
			draws_in_flight <= pending_draws.size();
			mismatch_count <= errors_seen;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the exponential variate generator core
// depends on erv_pkg, erv_if, the core rtl and erv_draw_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import erv_pkg::*;

	localparam int unsigned LOG_FRACTION_BITS = 24;
	// settle time covers the longest request, with margin on top
	localparam int unsigned SETTLE_CYCLES = LOG_FRACTION_BITS + 40;
	localparam int unsigned PHASE_DRAWS = 260;
	localparam int unsigned PHASES = 6;
	// seeds whose next draw lands on m-1 and on 1
	localparam logic [31:0] SEED_TO_TOP = 32'd739806647;
	localparam logic [31:0] SEED_TO_ONE = 32'd1407677000;

	logic        clk;
	logic        arst_n;
	int unsigned draws_in_flight;
	int unsigned mismatch_count;
	bit          source_gaps;
	bit          sink_stalls;

	erv_req_if req_ch();
	erv_res_if res_ch();
	erv_cfg_if cfg_ch();

	exponential_random_variate_generator_core #(
		.LOG_FRACTION_BITS(LOG_FRACTION_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	erv_draw_checker #(
		.LOG_FRACTION_BITS(LOG_FRACTION_BITS)
	) i_draw_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch),
		.draws_in_flight(draws_in_flight),
		.mismatch_count(mismatch_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result sink with random stall bursts
	initial begin
		int unsigned hold;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 14);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// one request, with an optional idle burst ahead of it; ends on a falling edge
	task automatic send_request(input logic draw);
		int unsigned gap;
		if (source_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.request <= draw;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// stop sending until every predicted draw has come back
	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (draws_in_flight != 0);
	endtask

	// drain, then give a dropped request time to leave the pipe
	task automatic quiesce();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic write_reg(input erv_cfg_idx_t idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// a run of draws mixed with dropped requests
	task automatic run_draws(input int unsigned count);
		int unsigned drawn;
		drawn = 0;
		while (drawn < count) begin
			if ($urandom_range(0, 7) == 0) begin
				send_request(1'b0);
			end else begin
				send_request(1'b1);
				drawn++;
			end
			if (source_gaps && $urandom_range(0, 99) == 0)
				hold_until_drained();
		end
	endtask

	function automatic logic [31:0] pick_decay();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd65536;
			3: return $urandom_range(0, 32'h000F_FFFF);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_seed();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'(LCG_MOD) - 32'd1;
			2: return 32'(LCG_MOD);
			3: return SEED_TO_TOP;
			4: return SEED_TO_ONE;
			default: return $urandom_range(0, 32'(LCG_MOD) - 32'd1);
		endcase
	endfunction

	// main sequence
	initial begin
		int unsigned phase;
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.request = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_DECAY;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset config, dropped request, register extremes, seed corner cases
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		quiesce();
		write_reg(CFG_DECAY, 32'd0);
		send_request(1'b1);
		send_request(1'b1);
		quiesce();
		write_reg(CFG_DECAY, 32'hFFFF_FFFF);
		write_reg(CFG_START_SEED, SEED_TO_TOP);
		send_request(1'b1);
		send_request(1'b1);
		quiesce();
		write_reg(CFG_START_SEED, 32'd0);
		send_request(1'b1);
		quiesce();
		write_reg(CFG_START_SEED, 32'(LCG_MOD));
		send_request(1'b1);
		quiesce();
		write_reg(CFG_START_SEED, 32'(LCG_MOD) - 32'd1);
		send_request(1'b1);
		send_request(1'b1);
		quiesce();
		write_reg(CFG_DECAY, 32'd1);
		write_reg(CFG_START_SEED, SEED_TO_ONE);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		quiesce();
		write_reg(CFG_DECAY, 32'hFFFF_0000);
		write_reg(CFG_START_SEED, SEED_TO_TOP);
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b1);

		// random phases, the last one without idling on either side
		for (phase = 0; phase < PHASES; phase++) begin
			quiesce();
			source_gaps = (phase != PHASES - 1);
			sink_stalls = (phase != PHASES - 1);
			write_reg(CFG_DECAY, pick_decay());
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_START_SEED, pick_seed());
			run_draws(PHASE_DRAWS);
		end

		quiesce();
		if (mismatch_count == 0 && draws_in_flight == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/erv_pkg.sv
design/erv_if.sv
design/erv_mul.sv
design/erv_seq.sv
design/exponential_random_variate_generator_core.sv
tb/erv_draw_checker.sv
tb/testbench.sv
